// ----- rtl/core/spq_pkg.sv -----
// Package for the sorted priority queue: operation codes, control struct
// and default sizes. No dependencies; used by spq_cell and the top level.
package spq_pkg;

	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam int DEF_CAPACITY      = 16;
	localparam int DEF_PRIORITY_BITS = 8;
	localparam int DEF_PAYLOAD_BITS  = 16;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctl_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
// One storage cell of the queue chain: holds one entry and loads from the
// new item, its upper neighbor or its lower neighbor. Depends on spq_pkg.
module spq_cell #(
	parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS
) (
	input  logic                     clk,
	input  spq_pkg::spq_ctl_t        ctl,
	input  logic                     slot_valid,
	input  logic [PRIORITY_BITS-1:0] new_prio,
	input  logic [PAYLOAD_BITS-1:0]  new_pay,
	input  logic                     up_keep,
	input  logic [PRIORITY_BITS-1:0] up_prio,
	input  logic [PAYLOAD_BITS-1:0]  up_pay,
	input  logic [PRIORITY_BITS-1:0] down_prio,
	input  logic [PAYLOAD_BITS-1:0]  down_pay,
	output logic                     keep,
	output logic [PRIORITY_BITS-1:0] prio,
	output logic [PAYLOAD_BITS-1:0]  pay
);
	import spq_pkg::*;

	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;

	// The entry stays in place on a push when it outranks the new item.
	assign keep = slot_valid && (prio_q > new_prio);
	assign prio = prio_q;
	assign pay  = pay_q;

	always_ff @(posedge clk) begin
		if (ctl.push && !keep) begin
			if (up_keep) begin
				prio_q <= new_prio;
				pay_q  <= new_pay;
			end else begin
				prio_q <= up_prio;
				pay_q  <= up_pay;
			end
		end else if (ctl.pop) begin
			prio_q <= down_prio;
			pay_q  <= down_pay;
		end
	end

endmodule

// ----- rtl/core/sorted_priority_queue_top.sv -----
// Top level of the sorted priority queue: a chain of spq_cell instances,
// the entry count and the result register. Depends on spq_pkg and spq_cell.
//
//  Channel   Handshake            Ports
//  --------  -------------------  ---------------------------------------------
//  command   start & !busy        op, item_priority, item_payload
//  result    done (one cycle)     found, out_priority, out_payload, accepted,
//                                 entry_count, is_empty
//
// Every accepted item produces exactly one result, shown with done high for
// one cycle on the clock edge after the item was accepted. The chain of cells
// finishes a push or a pop at the edge that takes the item, so busy is never raised and a
// new item can be given every cycle; the rate is one item per clock.
// The asynchronous reset empties the queue by clearing the entry count; the
// cell contents are left as they are and are never read until written.
// The receiver cannot hold results off, and none is needed since each result
// lives in the output register until the next one replaces it.
module sorted_priority_queue_top #(
	parameter int  CAPACITY      = spq_pkg::DEF_CAPACITY,
	parameter int  PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS,
	parameter int  PAYLOAD_BITS  = spq_pkg::DEF_PAYLOAD_BITS,
	localparam int CNT_W         = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [spq_pkg::OP_W-1:0]      op,
	input  logic [PRIORITY_BITS-1:0]      item_priority,
	input  logic [PAYLOAD_BITS-1:0]       item_payload,
	output logic                          done,
	output logic                          found,
	output logic [PRIORITY_BITS-1:0]      out_priority,
	output logic [PAYLOAD_BITS-1:0]       out_payload,
	output logic                          accepted,
	output logic [CNT_W-1:0]              entry_count,
	output logic                          is_empty
);
	import spq_pkg::*;

	// Cell 0 holds the entry that leaves next: the largest priority and,
	// among equal priorities, the newest one. Lower cells follow in order.
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     take;
	logic                     q_full;
	logic                     q_empty;
	logic                     do_read;
	spq_ctl_t                 ctl;

	logic [CAPACITY-1:0]      cell_keep;
	logic [PRIORITY_BITS-1:0] cell_prio [CAPACITY];
	logic [PAYLOAD_BITS-1:0]  cell_pay  [CAPACITY];

	logic                     done_q;
	logic                     found_q;
	logic [PRIORITY_BITS-1:0] prio_q;
	logic [PAYLOAD_BITS-1:0]  pay_q;
	logic                     accepted_q;
	logic [CNT_W-1:0]         cnt_out_q;

	assign busy    = 1'b0;
	assign take    = start && !busy;
	assign q_full  = (count_q == CNT_W'(CAPACITY));
	assign q_empty = (count_q == '0);

	// A push into a full queue and a pop of an empty one leave the cells alone.
	assign ctl.push = take && (op == OP_PUSH) && !q_full;
	assign ctl.pop  = take && (op == OP_POP) && !q_empty;
	assign do_read  = take && ((op == OP_POP) || (op == OP_PEEK)) && !q_empty;

	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// The chain. Cell 0 sees an upper neighbor that always outranks the new
	// item, so it takes the new item whenever it does not keep its own entry.
	// The last cell shifts in don't-care data on a pop; the count drops past it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     up_keep;
		logic [PRIORITY_BITS-1:0] up_prio;
		logic [PAYLOAD_BITS-1:0]  up_pay;
		logic [PRIORITY_BITS-1:0] down_prio;
		logic [PAYLOAD_BITS-1:0]  down_pay;

		if (i == 0) begin : g_first
			assign up_keep = 1'b1;
			assign up_prio = item_priority;
			assign up_pay  = item_payload;
		end else begin : g_inner_up
			assign up_keep = cell_keep[i-1];
			assign up_prio = cell_prio[i-1];
			assign up_pay  = cell_pay[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign down_prio = '0;
			assign down_pay  = '0;
		end else begin : g_inner_down
			assign down_prio = cell_prio[i+1];
			assign down_pay  = cell_pay[i+1];
		end

		spq_cell #(
			.PRIORITY_BITS (PRIORITY_BITS),
			.PAYLOAD_BITS  (PAYLOAD_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.slot_valid (CNT_W'(i) < count_q),
			.new_prio   (item_priority),
			.new_pay    (item_payload),
			.up_keep    (up_keep),
			.up_prio    (up_prio),
			.up_pay     (up_pay),
			.down_prio  (down_prio),
			.down_pay   (down_pay),
			.keep       (cell_keep[i]),
			.prio       (cell_prio[i]),
			.pay        (cell_pay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= take;
		end
	end

	// Result register; the head entry is read before the chain shifts.
	always_ff @(posedge clk) begin
		if (take) begin
			found_q    <= do_read;
			prio_q     <= do_read ? cell_prio[0] : '0;
			pay_q      <= do_read ? cell_pay[0] : '0;
			accepted_q <= ctl.push;
			cnt_out_q  <= count_nxt;
		end
	end

	assign done         = done_q;
	assign found        = found_q;
	assign out_priority = prio_q;
	assign out_payload  = pay_q;
	assign accepted     = accepted_q;
	assign entry_count  = cnt_out_q;
	assign is_empty     = (cnt_out_q == '0);

	// The count never passes the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// Every accepted item gives its result on the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("accepted item produced no result");

	// A result is never both a returned entry and a stored push.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && accepted))
		else $error("result both found and accepted");

	// A stored push raises the reported count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		take && ctl.push |=> (entry_count == $past(count_q) + CNT_W'(1)))
		else $error("push did not raise the count");

	// A pop that returned an entry lowers the count by one.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> found && (entry_count == $past(count_q) - CNT_W'(1)))
		else $error("pop did not lower the count");

endmodule

// ----- tb/tb_sorted_priority_queue_top.sv -----
// Self-checking testbench for sorted_priority_queue_top: directed and random push, pop,
// peek and no-op items, each result compared against an in-bench shadow of the queue.
// Depends on spq_pkg and the sorted_priority_queue_top RTL only.
module tb_sorted_priority_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int CAP    = DEF_CAPACITY;
	localparam int PRIO_W = DEF_PRIORITY_BITS;
	localparam int PAY_W  = DEF_PAYLOAD_BITS;
	localparam int CNT_W  = $clog2(CAP + 1);

	// The fourth op code has no meaning in the block and must act as a no-op.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	localparam int N_RANDOM     = 1250;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} request_t;

	typedef struct packed {
		logic              found;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
		logic              acc;
		logic [CNT_W-1:0]  count;
		logic              empty;
	} outcome_t;

	// Clock, reset and DUT ports. Every input starts at a known value.
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   op = OP_NONE;
	logic [PRIO_W-1:0] item_priority = '0;
	logic [PAY_W-1:0]  item_payload = '0;
	logic              busy;
	logic              done;
	logic              found;
	logic [PRIO_W-1:0] out_priority;
	logic [PAY_W-1:0]  out_payload;
	logic              accepted;
	logic [CNT_W-1:0]  entry_count;
	logic              is_empty;

	sorted_priority_queue_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.item_priority (item_priority),
		.item_payload  (item_payload),
		.done          (done),
		.found         (found),
		.out_priority  (out_priority),
		.out_payload   (out_payload),
		.accepted      (accepted),
		.entry_count   (entry_count),
		.is_empty      (is_empty)
	);

	always #10 clk = ~clk;

	// Shadow copy of the sorted array: slot 0 holds the lowest priority, the top
	// valid slot holds the entry that the next pop returns.
	logic [PRIO_W-1:0] shadow_prio [CAP];
	logic [PAY_W-1:0]  shadow_pay [CAP];
	int                shadow_count = 0;

	request_t requests_pending [$];
	outcome_t outcomes_due [$];

	int   n_errors = 0;
	int   n_taken = 0;
	int   n_total = 0;
	int   cycle_count = 0;
	logic item_taken = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;

	// Applies one request to the shadow queue and returns the result that the
	// block must show for it.
	function automatic outcome_t serve_request(logic [OP_W-1:0] req_op,
			logic [PRIO_W-1:0] req_prio, logic [PAY_W-1:0] req_pay);
		outcome_t res;
		int       pos;
		res = '0;
		if (req_op == OP_PUSH) begin
			if (shadow_count < CAP) begin
				// Entries of strictly greater priority move up one slot, so the
				// new entry lands above every older entry of equal priority.
				pos = shadow_count;
				while (pos > 0 && shadow_prio[pos - 1] > req_prio) begin
					shadow_prio[pos] = shadow_prio[pos - 1];
					shadow_pay[pos] = shadow_pay[pos - 1];
					pos--;
				end
				shadow_prio[pos] = req_prio;
				shadow_pay[pos] = req_pay;
				shadow_count++;
				res.acc = 1'b1;
			end
		end else if (req_op == OP_POP || req_op == OP_PEEK) begin
			if (shadow_count > 0) begin
				res.found = 1'b1;
				res.prio = shadow_prio[shadow_count - 1];
				res.pay = shadow_pay[shadow_count - 1];
				if (req_op == OP_POP) begin
					shadow_count--;
				end
			end
		end
		res.count = CNT_W'(shadow_count);
		res.empty = (shadow_count == 0);
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			n_errors++;
		end
	endfunction

	function automatic void add_request(logic [OP_W-1:0] req_op, logic [PRIO_W-1:0] req_prio,
			logic [PAY_W-1:0] req_pay);
		request_t req;
		req.op = req_op;
		req.prio = req_prio;
		req.pay = req_pay;
		requests_pending.push_back(req);
	endfunction

	// Driver: works at the falling edge so that the block sees stable inputs at
	// the next rising edge. The sender runs in bursts of random length, with
	// random gaps between them; about a quarter of the bursts run straight into
	// the next one, which gives stretches of back-to-back items.
	always @(negedge clk) begin : drive_requests
		request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			// The block held the item off; keep it on the ports unchanged.
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (requests_pending.size() > 0) begin
			nxt = requests_pending.pop_front();
			op <= nxt.op;
			item_priority <= nxt.prio;
			item_payload <= nxt.pay;
			start <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: at each rising edge the result shown with done is compared with
	// the oldest expectation, and an item taken at this edge is run through the
	// shadow queue. The result of an item appears only after the edge that takes
	// it, so the check always sees expectations from earlier edges.
	always @(posedge clk) begin : check_outcomes
		outcome_t want;
		item_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					$error("result shown with no item outstanding");
					n_errors++;
				end else begin
					want = outcomes_due.pop_front();
					check_field("found", 32'(want.found), 32'(found));
					check_field("out_priority", 32'(want.prio), 32'(out_priority));
					check_field("out_payload", 32'(want.pay), 32'(out_payload));
					check_field("accepted", 32'(want.acc), 32'(accepted));
					check_field("entry_count", 32'(want.count), 32'(entry_count));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
				end
			end
			if (start && !busy) begin
				outcomes_due.push_back(serve_request(op, item_priority, item_payload));
				n_taken++;
			end
		end
	end

	// Watchdog: a run that stalls anywhere ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("tb_sorted_priority_queue_top failed");
			$finish;
		end
	end

	initial begin
		int i;
		int seg_left;
		int push_pct;
		int narrow;
		int roll;
		logic [OP_W-1:0]   r_op;
		logic [PRIO_W-1:0] r_prio;

		// Directed part. Pop, peek and the no-op on an empty queue come first.
		add_request(OP_POP, 8'd17, 16'h1234);
		add_request(OP_PEEK, 8'd255, 16'hFFFF);
		add_request(OP_NONE, 8'd255, 16'hFFFF);
		// Extremes of both fields, then an equal priority whose newer entry
		// must come out ahead of the older one.
		add_request(OP_PUSH, 8'd255, 16'hFFFF);
		add_request(OP_PUSH, 8'd0, 16'h0000);
		add_request(OP_PUSH, 8'd255, 16'h0001);
		add_request(OP_PEEK, 8'd0, 16'h0000);
		add_request(OP_NONE, 8'd0, 16'h0000);
		add_request(OP_POP, 8'd0, 16'h0000);
		add_request(OP_POP, 8'd0, 16'h0000);
		// One entry is left; fill up to capacity with a run of repeated
		// priorities mixed with random ones.
		for (i = 0; i < CAP - 1; i++) begin
			add_request(OP_PUSH, (i % 3 == 0) ? 8'd128 : PRIO_W'($urandom),
				PAY_W'(16'hA500 + i));
		end
		// A push into a full queue is dropped; a no-op reports the full count.
		add_request(OP_PUSH, 8'd255, 16'h5A5A);
		add_request(OP_NONE, 8'd1, 16'h0001);

		// Random part in segments. Each segment leans toward filling or draining
		// the queue, so it swings between empty and full many times; about half
		// the segments draw priorities from a few values at both ends to create
		// long runs of equal priorities.
		seg_left = 0;
		push_pct = 50;
		narrow = 0;
		for (i = 0; i < N_RANDOM; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 120);
				push_pct = $urandom_range(25, 75);
				narrow = $urandom_range(0, 1);
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				r_op = OP_NONE;
			end else if (roll < 3 + push_pct) begin
				r_op = OP_PUSH;
			end else if ($urandom_range(0, 4) == 0) begin
				r_op = OP_PEEK;
			end else begin
				r_op = OP_POP;
			end
			if (narrow != 0) begin
				r_prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 2))
					: PRIO_W'($urandom_range(253, 255));
			end else begin
				r_prio = PRIO_W'($urandom);
			end
			add_request(r_op, r_prio, PAY_W'($urandom));
		end
		n_total = requests_pending.size();

		// Reset is released at a falling edge, away from the rising edge.
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every item has been taken, then give the last results time
		// to come out before anything left over counts as missing.
		while (n_taken < n_total) @(posedge clk);
		for (i = 0; i < DRAIN_CYCLES && outcomes_due.size() > 0; i++) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
		if (outcomes_due.size() != 0) begin
			$error("%0d results never shown", outcomes_due.size());
			n_errors++;
		end

		if (n_errors == 0) begin
			$display("tb_sorted_priority_queue_top passed");
		end else begin
			$display("tb_sorted_priority_queue_top failed");
		end
		$finish;
	end

endmodule
